[rtl/mufx_pkg.sv]
package mufx_pkg;

   // pipeline depth from input register to output register
   localparam int PIPE_DEPTH = 8;

   // stage positions in the load vector
   localparam int STG_IN   = 0;  // sums, differences, normal
   localparam int STG_X1R  = 1;  // first cross products, raw
   localparam int STG_X1   = 2;  // first cross products, rounded
   localparam int STG_SCR  = 3;  // coefficient products, raw
   localparam int STG_SC   = 4;  // averages and scaled jumps
   localparam int STG_X2R  = 5;  // normal cross scaled jump, raw
   localparam int STG_X2   = 6;  // penalty terms, rounded
   localparam int STG_OUT  = 7;  // final flux

   localparam int NUM_COEF     = 6;
   localparam int CSR_IDX_BITS = 3;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      COEF_EX = 3'd0,
      COEF_EY = 3'd1,
      COEF_EZ = 3'd2,
      COEF_HX = 3'd3,
      COEF_HY = 3'd4,
      COEF_HZ = 3'd5
   } coef_idx_type;

   // handshake control handed from the pipeline controller to the datapath
   typedef struct packed {
      logic [PIPE_DEPTH-1:0] load;
      logic                  in_ready;
      logic                  out_valid;
   } pipe_ctl_type;

endpackage

[rtl/mufx_rndsat.sv]
// Round half up by SH bits, then clamp to a signed OW-bit range.
module mufx_rndsat #(
   parameter int IW = 34,
   parameter int SH = 12,
   parameter int OW = 23
) (
   input  logic signed [IW-1:0] din,
   output logic signed [OW-1:0] dout
);

   localparam int QW = IW - SH + 1;
   localparam int CW = (QW > OW) ? QW : OW;
   localparam logic signed [IW:0]   HALF = (IW+1)'(1) << (SH-1);
   localparam logic signed [CW-1:0] SMAX = CW'({1'b0, {(OW-1){1'b1}}});
   localparam logic signed [CW-1:0] SMIN = ~SMAX;

   logic signed [IW:0]   biased;
   logic signed [QW-1:0] quo;
   logic signed [CW-1:0] quo_ext;

   // bias, arithmetic shift, saturate
   always_comb begin
      biased  = (IW+1)'(din) + HALF;
      quo     = biased[IW:SH];
      quo_ext = CW'(quo);
      if (quo_ext > SMAX) begin
         dout = SMAX[OW-1:0];
      end else if (quo_ext < SMIN) begin
         dout = SMIN[OW-1:0];
      end else begin
         dout = quo_ext[OW-1:0];
      end
   end

endmodule

[rtl/mufx_pipe_ctl.sv]
// Valid bits and per-stage ready chain; bubbles collapse under a stall.
module mufx_pipe_ctl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic                    out_ready,
   output mufx_pkg::pipe_ctl_type  ctl
);

   localparam int D = mufx_pkg::PIPE_DEPTH;

   logic [D-1:0] vld_ff;
   logic [D-1:0] vld_in;
   logic [D-1:0] rdy;

   // a stage may load when it is empty or its content moves on
   always_comb begin
      rdy[D-1] = !vld_ff[D-1] || out_ready;
      for (int i = D-2; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
      vld_in[0] = rdy[0] ? in_valid : vld_ff[0];
      for (int i = 1; i < D; i++) begin
         vld_in[i] = rdy[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      ctl.load      = rdy;
      ctl.in_ready  = rdy[0];
      ctl.out_valid = vld_ff[D-1];
   end

endmodule

[rtl/mufx_csr.sv]
// Material coefficient registers, one write beat per cycle.
module mufx_csr #(
   parameter int WORD_BITS = 16,
   parameter int FRAC_BITS = 12
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         csr_valid,
   output logic                                         csr_ready,
   input  logic [mufx_pkg::CSR_IDX_BITS-1:0]            csr_index,
   input  logic [WORD_BITS-1:0]                         csr_wdata,
   output logic [mufx_pkg::NUM_COEF*WORD_BITS-1:0]      coef_vec
);

   localparam int W = WORD_BITS;
   localparam logic [W-1:0] COEF_ONE = W'(1) << FRAC_BITS;

   logic [W-1:0] coef_ff [mufx_pkg::NUM_COEF];

   assign csr_ready = 1'b1;

   // writes to unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mufx_pkg::NUM_COEF; i++) begin
            coef_ff[i] <= COEF_ONE;
         end
      end else if (csr_valid) begin
         unique case (mufx_pkg::coef_idx_type'(csr_index))
            mufx_pkg::COEF_EX: coef_ff[0] <= csr_wdata;
            mufx_pkg::COEF_EY: coef_ff[1] <= csr_wdata;
            mufx_pkg::COEF_EZ: coef_ff[2] <= csr_wdata;
            mufx_pkg::COEF_HX: coef_ff[3] <= csr_wdata;
            mufx_pkg::COEF_HY: coef_ff[4] <= csr_wdata;
            mufx_pkg::COEF_HZ: coef_ff[5] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < mufx_pkg::NUM_COEF; i++) begin
         coef_vec[i*W +: W] = coef_ff[i];
      end
   end

endmodule

[rtl/mufx_cross.sv]
// Two-stage cross product a x b: raw products, then round and saturate.
module mufx_cross #(
   parameter int AW = 16,
   parameter int BW = 17,
   parameter int SH = 12,
   parameter int OW = 23
) (
   input  logic              clock,
   input  logic              load_raw,
   input  logic              load_out,
   input  logic [3*AW-1:0]   a_vec,
   input  logic [3*BW-1:0]   b_vec,
   output logic [3*OW-1:0]   c_vec
);

   localparam int RW = AW + BW + 1;

   logic signed [AW-1:0] a [3];
   logic signed [BW-1:0] b [3];
   logic signed [RW-1:0] raw_in [3];
   logic signed [RW-1:0] raw_ff [3];
   logic signed [OW-1:0] c_in [3];
   logic [3*OW-1:0]      c_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         a[k] = a_vec[k*AW +: AW];
         b[k] = b_vec[k*BW +: BW];
      end
      raw_in[0] = a[1] * b[2] - a[2] * b[1];
      raw_in[1] = a[2] * b[0] - a[0] * b[2];
      raw_in[2] = a[0] * b[1] - a[1] * b[0];
   end

   always_ff @(posedge clock) begin
      if (load_raw) begin
         raw_ff <= raw_in;
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_rnd
      mufx_rndsat #(.IW(RW), .SH(SH), .OW(OW)) u_rndsat (
         .din  (raw_ff[k]),
         .dout (c_in[k])
      );
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         for (int k = 0; k < 3; k++) begin
            c_ff[k*OW +: OW] <= c_in[k];
         end
      end
   end

   assign c_vec = c_ff;

endmodule

[rtl/mufx_scale.sv]
// Two-stage per-component coefficient scale: product, then round and saturate.
module mufx_scale #(
   parameter int W  = 16,
   parameter int TW = 23,
   parameter int SH = 13,
   parameter int OW = 26
) (
   input  logic              clock,
   input  logic              load_raw,
   input  logic              load_out,
   input  logic [3*W-1:0]    coef_vec,
   input  logic [3*TW-1:0]   t_vec,
   output logic [3*OW-1:0]   s_vec
);

   localparam int PW = W + TW;

   logic signed [W-1:0]  c [3];
   logic signed [TW-1:0] t [3];
   logic signed [PW-1:0] prod_in [3];
   logic signed [PW-1:0] prod_ff [3];
   logic signed [OW-1:0] s_in [3];
   logic [3*OW-1:0]      s_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         c[k]       = coef_vec[k*W +: W];
         t[k]       = t_vec[k*TW +: TW];
         prod_in[k] = c[k] * t[k];
      end
   end

   always_ff @(posedge clock) begin
      if (load_raw) begin
         prod_ff <= prod_in;
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_rnd
      mufx_rndsat #(.IW(PW), .SH(SH), .OW(OW)) u_rndsat (
         .din  (prod_ff[k]),
         .dout (s_in[k])
      );
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         for (int k = 0; k < 3; k++) begin
            s_ff[k*OW +: OW] <= s_in[k];
         end
      end
   end

   assign s_vec = s_ff;

endmodule

[rtl/maxwell_upwind_face_flux.sv]
// Upwind Maxwell face flux, left side, for one quadrature point per beat.
// Fully pipelined: a new point is accepted every cycle unless a stalled
// rsp_ready holds the pipeline. Its six flux words pass through the input
// register, two cross-product stages, two coefficient stages, two
// normal-cross stages and the output register. Each stage loads when it
// is empty or its content moves on, so a stalled rsp_ready fills the
// pipeline up to 8 points before req_ready drops, and bubbles are
// squeezed out. Coefficients reset to 1.0 (Q.FRAC_BITS) and must only be
// written while no point is in flight; csr_ready is always high.
module maxwell_upwind_face_flux #(
   parameter int WORD_BITS = 16,
   parameter int FRAC_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // point input
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [3*WORD_BITS-1:0]               req_e_left,
   input  logic [3*WORD_BITS-1:0]               req_h_left,
   input  logic [3*WORD_BITS-1:0]               req_e_right,
   input  logic [3*WORD_BITS-1:0]               req_h_right,
   input  logic [3*WORD_BITS-1:0]               req_normal_vec,
   // flux output
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [WORD_BITS-1:0]          rsp_flux_ex,
   output logic signed [WORD_BITS-1:0]          rsp_flux_ey,
   output logic signed [WORD_BITS-1:0]          rsp_flux_ez,
   output logic signed [WORD_BITS-1:0]          rsp_flux_hx,
   output logic signed [WORD_BITS-1:0]          rsp_flux_hy,
   output logic signed [WORD_BITS-1:0]          rsp_flux_hz,
   // coefficient writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mufx_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [WORD_BITS-1:0]                 csr_wdata
);

   localparam int W   = WORD_BITS;
   localparam int F   = FRAC_BITS;
   localparam int W2  = 2 * W;
   // sums and differences
   localparam int VW  = W + 1;
   // first cross product after rounding
   localparam int TQ  = 2*W + 3 - F;
   localparam int TW  = (TQ < W2) ? TQ : W2;
   // averaged terms
   localparam int AQ  = W + TW - F;
   localparam int AVW = (AQ < W2) ? AQ : W2;
   // scaled jumps
   localparam int JQ  = W + TW - F + 1;
   localparam int JW  = (JQ < W2) ? JQ : W2;
   // penalty terms
   localparam int PQ  = W + JW + 1 - F;
   localparam int PW  = (PQ < W2) ? PQ : W2;
   // final sum
   localparam int SW  = ((PW > AVW) ? PW : AVW) + 1;
   localparam logic signed [SW-1:0] OMAX = SW'({1'b0, {(W-1){1'b1}}});
   localparam logic signed [SW-1:0] OMIN = ~OMAX;

   localparam int NC = mufx_pkg::NUM_COEF;

   mufx_pkg::pipe_ctl_type ctl;

   logic [NC*W-1:0] coef_vec;

   logic signed [VW-1:0] el_x [3];
   logic signed [VW-1:0] hl_x [3];
   logic signed [VW-1:0] er_x [3];
   logic signed [VW-1:0] hr_x [3];

   logic [3*VW-1:0] hs_in, es_in, de_in, dh_in;
   logic [3*VW-1:0] hs_ff, es_ff, de_ff, dh_ff;
   logic [3*W-1:0]  n_ff [mufx_pkg::STG_SC+1];

   logic [3*TW-1:0]  t_hs, t_es, t_de, t_dh;
   logic [3*AVW-1:0] avg_e, avg_h;
   logic [3*JW-1:0]  w_e, w_h;
   logic [3*PW-1:0]  pen_e, pen_h;
   logic [6*AVW-1:0] avg5_ff, avg6_ff;

   logic signed [PW-1:0]  pv [NC];
   logic signed [AVW-1:0] av [NC];
   logic signed [SW-1:0]  sm [NC];
   logic signed [W-1:0]   flux_in [NC];
   logic signed [W-1:0]   flux_ff [NC];

   // handshake control
   mufx_pipe_ctl u_pipe_ctl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .out_ready (rsp_ready),
      .ctl       (ctl)
   );

   assign req_ready = ctl.in_ready;
   assign rsp_valid = ctl.out_valid;

   // coefficient registers
   mufx_csr #(.WORD_BITS(W), .FRAC_BITS(F)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coef_vec  (coef_vec)
   );

   // field sums and jumps
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         el_x[k] = VW'(signed'(req_e_left[k*W +: W]));
         hl_x[k] = VW'(signed'(req_h_left[k*W +: W]));
         er_x[k] = VW'(signed'(req_e_right[k*W +: W]));
         hr_x[k] = VW'(signed'(req_h_right[k*W +: W]));
         hs_in[k*VW +: VW] = hl_x[k] + hr_x[k];
         es_in[k*VW +: VW] = el_x[k] + er_x[k];
         de_in[k*VW +: VW] = el_x[k] - er_x[k];
         dh_in[k*VW +: VW] = hl_x[k] - hr_x[k];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[mufx_pkg::STG_IN]) begin
         hs_ff    <= hs_in;
         es_ff    <= es_in;
         de_ff    <= de_in;
         dh_ff    <= dh_in;
         n_ff[0]  <= req_normal_vec;
      end
      // normal travels alongside until the second cross product
      for (int i = 1; i <= mufx_pkg::STG_SC; i++) begin
         if (ctl.load[i]) begin
            n_ff[i] <= n_ff[i-1];
         end
      end
   end

   // n x (HL+HR), n x (EL+ER), n x [E], n x [H]
   mufx_cross #(.AW(W), .BW(VW), .SH(F), .OW(TW)) u_x_hs (
      .clock (clock), .load_raw (ctl.load[mufx_pkg::STG_X1R]),
      .load_out (ctl.load[mufx_pkg::STG_X1]),
      .a_vec (n_ff[0]), .b_vec (hs_ff), .c_vec (t_hs)
   );
   mufx_cross #(.AW(W), .BW(VW), .SH(F), .OW(TW)) u_x_es (
      .clock (clock), .load_raw (ctl.load[mufx_pkg::STG_X1R]),
      .load_out (ctl.load[mufx_pkg::STG_X1]),
      .a_vec (n_ff[0]), .b_vec (es_ff), .c_vec (t_es)
   );
   mufx_cross #(.AW(W), .BW(VW), .SH(F), .OW(TW)) u_x_de (
      .clock (clock), .load_raw (ctl.load[mufx_pkg::STG_X1R]),
      .load_out (ctl.load[mufx_pkg::STG_X1]),
      .a_vec (n_ff[0]), .b_vec (de_ff), .c_vec (t_de)
   );
   mufx_cross #(.AW(W), .BW(VW), .SH(F), .OW(TW)) u_x_dh (
      .clock (clock), .load_raw (ctl.load[mufx_pkg::STG_X1R]),
      .load_out (ctl.load[mufx_pkg::STG_X1]),
      .a_vec (n_ff[0]), .b_vec (dh_ff), .c_vec (t_dh)
   );

   // coefficient scaling: averages carry the extra halving
   mufx_scale #(.W(W), .TW(TW), .SH(F+1), .OW(AVW)) u_sc_avg_e (
      .clock (clock), .load_raw (ctl.load[mufx_pkg::STG_SCR]),
      .load_out (ctl.load[mufx_pkg::STG_SC]),
      .coef_vec (coef_vec[0 +: 3*W]), .t_vec (t_hs), .s_vec (avg_e)
   );
   mufx_scale #(.W(W), .TW(TW), .SH(F+1), .OW(AVW)) u_sc_avg_h (
      .clock (clock), .load_raw (ctl.load[mufx_pkg::STG_SCR]),
      .load_out (ctl.load[mufx_pkg::STG_SC]),
      .coef_vec (coef_vec[3*W +: 3*W]), .t_vec (t_es), .s_vec (avg_h)
   );
   mufx_scale #(.W(W), .TW(TW), .SH(F), .OW(JW)) u_sc_w_e (
      .clock (clock), .load_raw (ctl.load[mufx_pkg::STG_SCR]),
      .load_out (ctl.load[mufx_pkg::STG_SC]),
      .coef_vec (coef_vec[0 +: 3*W]), .t_vec (t_de), .s_vec (w_e)
   );
   mufx_scale #(.W(W), .TW(TW), .SH(F), .OW(JW)) u_sc_w_h (
      .clock (clock), .load_raw (ctl.load[mufx_pkg::STG_SCR]),
      .load_out (ctl.load[mufx_pkg::STG_SC]),
      .coef_vec (coef_vec[3*W +: 3*W]), .t_vec (t_dh), .s_vec (w_h)
   );

   // half of n x scaled jump
   mufx_cross #(.AW(W), .BW(JW), .SH(F+1), .OW(PW)) u_x_we (
      .clock (clock), .load_raw (ctl.load[mufx_pkg::STG_X2R]),
      .load_out (ctl.load[mufx_pkg::STG_X2]),
      .a_vec (n_ff[mufx_pkg::STG_SC]), .b_vec (w_e), .c_vec (pen_e)
   );
   mufx_cross #(.AW(W), .BW(JW), .SH(F+1), .OW(PW)) u_x_wh (
      .clock (clock), .load_raw (ctl.load[mufx_pkg::STG_X2R]),
      .load_out (ctl.load[mufx_pkg::STG_X2]),
      .a_vec (n_ff[mufx_pkg::STG_SC]), .b_vec (w_h), .c_vec (pen_h)
   );

   // averages wait for the penalty terms
   always_ff @(posedge clock) begin
      if (ctl.load[mufx_pkg::STG_X2R]) begin
         avg5_ff <= {avg_h, avg_e};
      end
      if (ctl.load[mufx_pkg::STG_X2]) begin
         avg6_ff <= avg5_ff;
      end
   end

   // E: pen - avg; H average enters negated, so pen + avg
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pv[k]   = pen_e[k*PW +: PW];
         pv[k+3] = pen_h[k*PW +: PW];
      end
      for (int k = 0; k < NC; k++) begin
         av[k] = avg6_ff[k*AVW +: AVW];
         if (k < 3) begin
            sm[k] = SW'(pv[k]) - SW'(av[k]);
         end else begin
            sm[k] = SW'(pv[k]) + SW'(av[k]);
         end
         if (sm[k] > OMAX) begin
            flux_in[k] = OMAX[W-1:0];
         end else if (sm[k] < OMIN) begin
            flux_in[k] = OMIN[W-1:0];
         end else begin
            flux_in[k] = sm[k][W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[mufx_pkg::STG_OUT]) begin
         flux_ff <= flux_in;
      end
   end

   assign rsp_flux_ex = flux_ff[0];
   assign rsp_flux_ey = flux_ff[1];
   assign rsp_flux_ez = flux_ff[2];
   assign rsp_flux_hx = flux_ff[3];
   assign rsp_flux_hy = flux_ff[4];
   assign rsp_flux_hz = flux_ff[5];

`ifndef SYNTHESIS
   // an empty output stage means every stage can load
   a_empty_out_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output stage");

   // a draining output lets the whole pipeline advance
   a_drain_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output drains");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule

[dv/maxwell_upwind_face_flux_tb.sv]
`timescale 1ns / 1ps

localparam int FLUX_WORD_BITS = 16;
localparam int FLUX_FRAC_BITS = 12;

// six flux words of one beat, index 0..5 = ex, ey, ez, hx, hy, hz
typedef logic [5:0][FLUX_WORD_BITS-1:0] flux_set_type;

// Predicts the left-side upwind flux and holds the fluxes still owed by the block
class flux_checker;
   longint       coef[mufx_pkg::NUM_COEF];
   flux_set_type flux_due[$];
   int           errors;
   string        comp_name[6] = '{"flux_ex", "flux_ey", "flux_ez",
                                  "flux_hx", "flux_hy", "flux_hz"};

   function new();
      errors = 0;
      foreach (coef[i]) coef[i] = longint'(1) << FLUX_FRAC_BITS;
   endfunction

   // out-of-range index writes are dropped
   function void set_coef(int idx, logic [FLUX_WORD_BITS-1:0] val);
      if (idx < mufx_pkg::NUM_COEF) coef[idx] = longint'(signed'(val));
   endfunction

   function longint word_of(logic [3*FLUX_WORD_BITS-1:0] v, int k);
      return longint'(signed'(v[k*FLUX_WORD_BITS +: FLUX_WORD_BITS]));
   endfunction

   // round half up, then arithmetic shift
   function longint round_shift(longint x, int s);
      return (x + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function longint clamp(longint x, int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) << (bits - 1)) - 1;
      lo = -hi - 1;
      if (x > hi) return hi;
      if (x < lo) return lo;
      return x;
   endfunction

   function longint sat_wide(longint x);
      return clamp(x, 2 * FLUX_WORD_BITS);
   endfunction

   function void cross3(input longint a[3], input longint b[3], output longint c[3]);
      c[0] = a[1] * b[2] - a[2] * b[1];
      c[1] = a[2] * b[0] - a[0] * b[2];
      c[2] = a[0] * b[1] - a[1] * b[0];
   endfunction

   function void note_point(logic [3*FLUX_WORD_BITS-1:0] el_v, logic [3*FLUX_WORD_BITS-1:0] hl_v,
                            logic [3*FLUX_WORD_BITS-1:0] er_v, logic [3*FLUX_WORD_BITS-1:0] hr_v,
                            logic [3*FLUX_WORD_BITS-1:0] n_v);
      longint       n[3], hs[3], es[3], de[3], dh[3], t[3], we[3], wh[3];
      longint       avg[6], pen[6];
      flux_set_type f;
      for (int k = 0; k < 3; k++) begin
         n[k]  = word_of(n_v, k);
         hs[k] = word_of(hl_v, k) + word_of(hr_v, k);
         es[k] = word_of(el_v, k) + word_of(er_v, k);
         de[k] = word_of(el_v, k) - word_of(er_v, k);
         dh[k] = word_of(hl_v, k) - word_of(hr_v, k);
      end
      // central average terms, halved
      cross3(n, hs, t);
      for (int k = 0; k < 3; k++)
         avg[k] = sat_wide(round_shift(coef[k] * sat_wide(round_shift(t[k], FLUX_FRAC_BITS)),
                                       FLUX_FRAC_BITS + 1));
      cross3(n, es, t);
      for (int k = 0; k < 3; k++)
         avg[3+k] = -sat_wide(round_shift(coef[3+k] * sat_wide(round_shift(t[k], FLUX_FRAC_BITS)),
                                          FLUX_FRAC_BITS + 1));
      // scaled jumps
      cross3(n, de, t);
      for (int k = 0; k < 3; k++)
         we[k] = sat_wide(round_shift(coef[k] * sat_wide(round_shift(t[k], FLUX_FRAC_BITS)),
                                      FLUX_FRAC_BITS));
      cross3(n, dh, t);
      for (int k = 0; k < 3; k++)
         wh[k] = sat_wide(round_shift(coef[3+k] * sat_wide(round_shift(t[k], FLUX_FRAC_BITS)),
                                      FLUX_FRAC_BITS));
      // penalty: half of n x scaled jump
      cross3(n, we, t);
      for (int k = 0; k < 3; k++) pen[k] = sat_wide(round_shift(t[k], FLUX_FRAC_BITS + 1));
      cross3(n, wh, t);
      for (int k = 0; k < 3; k++) pen[3+k] = sat_wide(round_shift(t[k], FLUX_FRAC_BITS + 1));
      for (int k = 0; k < 6; k++)
         f[k] = FLUX_WORD_BITS'(clamp(pen[k] - avg[k], FLUX_WORD_BITS));
      flux_due.push_back(f);
   endfunction

   function void check_flux(flux_set_type got);
      flux_set_type want;
      if (flux_due.size() == 0) begin
         if (errors < 10) $display("unexpected flux beat at %0t", $realtime);
         errors++;
         return;
      end
      want = flux_due.pop_front();
      for (int k = 0; k < 6; k++) begin
         if (got[k] !== want[k]) begin
            if (errors < 10)
               $display("%s mismatch at %0t: expected %0d, got %0d", comp_name[k], $realtime,
                        $signed(want[k]), $signed(got[k]));
            errors++;
         end
      end
   endfunction

   function int pending();
      return flux_due.size();
   endfunction
endclass

module maxwell_upwind_face_flux_tb;

   localparam int W = FLUX_WORD_BITS;
   localparam int IDX_BITS = mufx_pkg::CSR_IDX_BITS;
   localparam int PHASE_POINTS = 200;
   localparam int NUM_PHASES = 6;
   localparam logic [W-1:0] ONE_Q   = 16'h1000;
   localparam logic [W-1:0] NEG_ONE = 16'hF000;
   localparam logic [W-1:0] POS_MAX = 16'h7FFF;
   localparam logic [W-1:0] NEG_MAX = 16'h8000;
   localparam logic [W-1:0] INV_SQRT3 = 16'd2365;
   localparam logic [W-1:0] INV_SQRT2 = 16'd2896;
   // indexes past the last coefficient, writes must be dropped
   localparam logic [IDX_BITS-1:0] CSR_IDX_SPARE0 = IDX_BITS'(mufx_pkg::NUM_COEF);
   localparam logic [IDX_BITS-1:0] CSR_IDX_SPARE1 = IDX_BITS'(mufx_pkg::NUM_COEF + 1);

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [3*W-1:0]          req_e_left;
   logic [3*W-1:0]          req_h_left;
   logic [3*W-1:0]          req_e_right;
   logic [3*W-1:0]          req_h_right;
   logic [3*W-1:0]          req_normal_vec;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic signed [W-1:0]     rsp_flux_ex;
   logic signed [W-1:0]     rsp_flux_ey;
   logic signed [W-1:0]     rsp_flux_ez;
   logic signed [W-1:0]     rsp_flux_hx;
   logic signed [W-1:0]     rsp_flux_hy;
   logic signed [W-1:0]     rsp_flux_hz;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [IDX_BITS-1:0]     csr_index;
   logic [W-1:0]            csr_wdata;

   flux_checker flux_sb;
   bit          sink_stall_en;

   maxwell_upwind_face_flux u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_e_left     (req_e_left),
      .req_h_left     (req_h_left),
      .req_e_right    (req_e_right),
      .req_h_right    (req_h_right),
      .req_normal_vec (req_normal_vec),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_flux_ex    (rsp_flux_ex),
      .rsp_flux_ey    (rsp_flux_ey),
      .rsp_flux_ez    (rsp_flux_ez),
      .rsp_flux_hx    (rsp_flux_hx),
      .rsp_flux_hy    (rsp_flux_hy),
      .rsp_flux_hz    (rsp_flux_hz),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("maxwell_upwind_face_flux regression: fail");
      $finish;
   end

   // sink pacing: random stall bursts while enabled
   initial begin
      forever begin
         @(posedge clock);
         if (sink_stall_en && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // outputs are stable between negedge and the accepting posedge
   initial begin
      forever begin
         @(negedge clock);
         if (!reset && rsp_valid && rsp_ready)
            flux_sb.check_flux({rsp_flux_hz, rsp_flux_hy, rsp_flux_hx,
                                rsp_flux_ez, rsp_flux_ey, rsp_flux_ex});
      end
   end

   function automatic logic [3*W-1:0] vec3(logic [W-1:0] x, logic [W-1:0] y, logic [W-1:0] z);
      return {z, y, x};
   endfunction

   function automatic logic [W-1:0] rand_word();
      case ($urandom_range(0, 9))
         0: return POS_MAX;
         1: return NEG_MAX;
         2: return '0;
         3, 4, 5: return W'($urandom);
         default: return W'($urandom_range(0, 16383)) - W'(8192);
      endcase
   endfunction

   function automatic logic [3*W-1:0] rand_vec();
      return vec3(rand_word(), rand_word(), rand_word());
   endfunction

   function automatic logic [W-1:0] rand_sign(logic [W-1:0] mag);
      return $urandom_range(0, 1) ? mag : -mag;
   endfunction

   // mostly true unit normals, some arbitrary vectors
   function automatic logic [3*W-1:0] rand_normal();
      logic [W-1:0] w[3];
      case ($urandom_range(0, 5))
         0, 1: begin
            w = '{default: '0};
            w[$urandom_range(0, 2)] = rand_sign(ONE_Q);
         end
         2: begin
            foreach (w[k]) w[k] = rand_sign(INV_SQRT3);
         end
         3: begin
            foreach (w[k]) w[k] = rand_sign(INV_SQRT2);
            w[$urandom_range(0, 2)] = '0;
         end
         default: return rand_vec();
      endcase
      return vec3(w[0], w[1], w[2]);
   endfunction

   function automatic logic [W-1:0] rand_coef();
      case ($urandom_range(0, 6))
         0: return POS_MAX;
         1: return NEG_MAX;
         2: return '0;
         3: return ONE_Q;
         default: return W'($urandom);
      endcase
   endfunction

   // leaves csr_valid high so back-to-back writes need one assignment per edge
   task automatic write_coef(input logic [IDX_BITS-1:0] idx, input logic [W-1:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      do @(negedge clock); while (!csr_ready);
      flux_sb.set_coef(int'(idx), val);
      @(posedge clock);
   endtask

   task automatic program_coefs(input logic [W-1:0] ex, input logic [W-1:0] ey,
                                input logic [W-1:0] ez, input logic [W-1:0] hx,
                                input logic [W-1:0] hy, input logic [W-1:0] hz);
      write_coef(mufx_pkg::COEF_EX, ex);
      write_coef(mufx_pkg::COEF_EY, ey);
      write_coef(mufx_pkg::COEF_EZ, ez);
      write_coef(mufx_pkg::COEF_HX, hx);
      write_coef(mufx_pkg::COEF_HY, hy);
      write_coef(mufx_pkg::COEF_HZ, hz);
      write_coef(CSR_IDX_SPARE0, W'($urandom));
      write_coef(CSR_IDX_SPARE1, W'($urandom));
      csr_valid <= 1'b0;
   endtask

   // one point beat, optionally preceded by an idle burst
   task automatic send_point(input logic [3*W-1:0] el, input logic [3*W-1:0] hl,
                             input logic [3*W-1:0] er, input logic [3*W-1:0] hr,
                             input logic [3*W-1:0] nv, input bit may_idle);
      if (may_idle && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_e_left     <= el;
      req_h_left     <= hl;
      req_e_right    <= er;
      req_h_right    <= hr;
      req_normal_vec <= nv;
      req_valid      <= 1'b1;
      do @(negedge clock); while (!req_ready);
      flux_sb.note_point(el, hl, er, hr, nv);
      @(posedge clock);
   endtask

   // wait until every owed flux has come out, then let the pipe settle
   task automatic drain();
      while (flux_sb.pending() != 0) @(posedge clock);
      repeat (mufx_pkg::PIPE_DEPTH) @(posedge clock);
   endtask

   task automatic run_directed();
      logic [3*W-1:0] nx, ny, nz, all_max, all_min, all_ones;
      nx       = vec3(ONE_Q, '0, '0);
      ny       = vec3('0, ONE_Q, '0);
      nz       = vec3('0, '0, ONE_Q);
      all_max  = vec3(POS_MAX, POS_MAX, POS_MAX);
      all_min  = vec3(NEG_MAX, NEG_MAX, NEG_MAX);
      all_ones = '1;
      send_point('0, '0, '0, '0, '0, 1'b0);
      send_point(all_ones, all_ones, all_ones, all_ones, all_ones, 1'b0);
      send_point(all_max, '0, '0, '0, nx, 1'b0);
      send_point(all_max, all_max, all_max, all_max, all_max, 1'b0);
      send_point(all_min, all_min, all_min, all_min, all_min, 1'b0);
      // largest jumps
      send_point(all_max, all_min, all_min, all_max, nz, 1'b0);
      send_point(all_min, all_max, all_max, all_min, all_min, 1'b0);
      // largest sums
      send_point(all_max, all_min, all_max, all_min,
                 vec3(INV_SQRT3, INV_SQRT3, INV_SQRT3), 1'b0);
      // each axis, both signs
      send_point(rand_vec(), rand_vec(), rand_vec(), rand_vec(), nx, 1'b0);
      send_point(rand_vec(), rand_vec(), rand_vec(), rand_vec(), ny, 1'b0);
      send_point(rand_vec(), rand_vec(), rand_vec(), rand_vec(), nz, 1'b0);
      send_point(rand_vec(), rand_vec(), rand_vec(), rand_vec(), vec3(NEG_ONE, '0, '0), 1'b0);
      send_point(rand_vec(), rand_vec(), rand_vec(), rand_vec(), vec3('0, NEG_ONE, NEG_ONE), 1'b0);
      // non-unit normal taken as given
      send_point(rand_vec(), rand_vec(), rand_vec(), rand_vec(), vec3('0, 16'h2000, '0), 1'b0);
      send_point(all_max, all_min, '0, '0, all_max, 1'b0);
      // jump in only one field
      send_point(all_max, vec3(16'h0123, 16'hFEDC, 16'h0800), '0,
                 vec3(16'h0123, 16'hFEDC, 16'h0800), vec3(INV_SQRT2, INV_SQRT2, '0), 1'b0);
      send_point(vec3(16'h0400, 16'hF800, 16'h1000), all_min,
                 vec3(16'h0400, 16'hF800, 16'h1000), all_max, ny, 1'b0);
      // zero normal kills every term
      send_point(all_max, all_min, all_min, all_max, '0, 1'b0);
      req_valid <= 1'b0;
   endtask

   initial begin
      bit src_idle_en;
      flux_sb        = new();
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_e_left     = '0;
      req_h_left     = '0;
      req_e_right    = '0;
      req_h_right    = '0;
      req_normal_vec = '0;
      rsp_ready      = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      sink_stall_en  = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed points on reset coefficients, sink stalls on
      sink_stall_en = 1'b1;
      run_directed();
      drain();

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: program_coefs(ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q);
            1: program_coefs(POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX);
            2: program_coefs(NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX);
            3: program_coefs('0, '0, '0, '0, '0, '0);
            default: program_coefs(rand_coef(), rand_coef(), rand_coef(),
                                   rand_coef(), rand_coef(), rand_coef());
         endcase
         for (int i = 0; i < PHASE_POINTS; i++) begin
            // idling toggles in stretches; last phase runs at full rate
            if (i % 50 == 0) begin
               src_idle_en   = (p != NUM_PHASES - 1) && ($urandom_range(0, 2) != 0);
               sink_stall_en = (p != NUM_PHASES - 1) && ($urandom_range(0, 2) != 0);
            end
            send_point(rand_vec(), rand_vec(), rand_vec(), rand_vec(), rand_normal(),
                       src_idle_en);
         end
         req_valid <= 1'b0;
         drain();
      end

      repeat (3 * mufx_pkg::PIPE_DEPTH) @(posedge clock);
      if (flux_sb.errors == 0) begin
         $display("maxwell_upwind_face_flux regression: pass");
      end else begin
         $display("maxwell_upwind_face_flux regression: fail");
      end
      $finish;
   end

endmodule
